>>> hdl/dxyz_pkg.sv
// Shared types and constants for the depth/RGB to XYZ point unit.
// No dependencies; imported by every module of the block except dxyz_fifo.
package dxyz_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int SIZE_W     = 13;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 32;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int POS_W      = 36;
  localparam int DMAG_W     = 16;
  localparam int PROD1_W    = DMAG_W + INV_W;          // 48
  localparam int SPLIT_W    = PROD1_W / 2;             // 24
  localparam int PART_W     = SPLIT_W + DEPTH_W;       // 40
  localparam int PROD_W     = PROD1_W + DEPTH_W;       // 64
  localparam int ROUND_SH   = 20;
  localparam int MAG_W      = PROD_W - ROUND_SH;       // 44
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL    = 32'd8180890;

  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1) << (POS_W - 1);
  localparam logic [MAG_W-1:0] POS_LIMIT = NEG_LIMIT - MAG_W'(1);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SH - 1);

  typedef struct packed {
    logic [SIZE_W-1:0]   image_width;
    logic [SIZE_W-1:0]   image_height;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic [DMAG_W-1:0]  dx_mag;
    logic               dx_neg;
    logic [DMAG_W-1:0]  dy_mag;
    logic               dy_neg;
    logic [DEPTH_W-1:0] depth;
    logic [RGB_W-1:0]   rgb;
    logic               frame_end;
  } mid_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
    logic [DEPTH_W-1:0] z_mm;
    logic               point_valid;
    logic [RGB_W-1:0]   rgb_packed;
    logic               frame_end;
  } out_item_t;

endpackage

>>> hdl/depth_rgb_to_xyz_point_unit.sv
// Top level of the depth/RGB to XYZ point unit: configuration registers,
// front end, staging queue and back end. Depends on dxyz_pkg and all dxyz_* modules.
//
// Usage:
//   Input channel: drive depth_mm, red, green, blue with push high; a beat is
//   taken at a clock edge where push is high and full is low. Pixels arrive
//   in raster order; the block counts columns and rows itself.
//   Result channel: while empty is low the oldest point sits on x_pos, y_pos,
//   z_mm, point_valid, rgb_packed and frame_end; pop takes it.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no pixel is in flight.
// Path: a result passes the staging queue, two multiply stages, a rounding stage
//   and the result queue before it shows on the outputs.
// Throughput: one pixel per cycle sustained while pop keeps up; the multiply pipeline
//   is fully pipelined and issue is limited only by free result-queue slots.
// Stall: when pop stays low the result queue fills, issue stops, the 4-entry
//   staging queue fills and full goes high; nothing is dropped.
// Reset: rst clears the queues, the raster position to column 0, row 0, and
//   loads the default geometry (640x480, center 320/240, default focal).
module depth_rgb_to_xyz_point_unit
  import dxyz_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [DEPTH_W-1:0]    depth_mm,
  input  logic [COLOR_W-1:0]    red,
  input  logic [COLOR_W-1:0]    green,
  input  logic [COLOR_W-1:0]    blue,
  input  logic                  pop,
  output logic                  empty,
  output logic signed [POS_W-1:0] x_pos,
  output logic signed [POS_W-1:0] y_pos,
  output logic [DEPTH_W-1:0]    z_mm,
  output logic                  point_valid,
  output logic [RGB_W-1:0]      rgb_packed,
  output logic                  frame_end,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      accept;
  mid_item_t front_item;
  mid_item_t mid_item;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_pop;
  out_item_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.center_x     <= RST_CENTER_X;
      cfg.center_y     <= RST_CENTER_Y;
      cfg.inv_focal_x  <= RST_INV_FOCAL;
      cfg.inv_focal_y  <= RST_INV_FOCAL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIZE_W-1:0];
        REG_CENTER_X:     cfg.center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:  cfg.inv_focal_x  <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:  cfg.inv_focal_y  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  dxyz_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cfg      (cfg),
    .depth_mm (depth_mm),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .item     (front_item)
  );

  dxyz_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_item),
    .pop   (mid_pop),
    .rdata (mid_item),
    .full  (mid_full),
    .empty (mid_empty)
  );

  dxyz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign x_pos       = result.x_pos;
  assign y_pos       = result.y_pos;
  assign z_mm        = result.z_mm;
  assign point_valid = result.point_valid;
  assign rgb_packed  = result.rgb_packed;
  assign frame_end   = result.frame_end;

endmodule

>>> hdl/dxyz_fifo.sv
// Small first-word-fall-through queue in flip-flops.
// Generic in width and depth; no package dependency.
module dxyz_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hdl/dxyz_front.sv
// Front end: pixel position counters, offset from the principal point, frame flag.
// Depends on dxyz_pkg.
module dxyz_front
  import dxyz_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  cfg_t               cfg,
  input  logic [DEPTH_W-1:0] depth_mm,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output mid_item_t          item
);

  localparam int UW  = $clog2(MAX_WIDTH);
  localparam int VW  = $clog2(MAX_HEIGHT);
  localparam int UCW = (UW + 1 > SIZE_W) ? UW + 1 : SIZE_W;
  localparam int VCW = (VW + 1 > SIZE_W) ? VW + 1 : SIZE_W;
  localparam int USW = (UW + 4 > CENTER_W) ? UW + 4 : CENTER_W;
  localparam int VSW = (VW + 4 > CENTER_W) ? VW + 4 : CENTER_W;

  logic [UW-1:0]  column;
  logic [VW-1:0]  row;
  logic [UCW-1:0] w_eff;
  logic [VCW-1:0] h_eff;
  logic           last_col;
  logic           last_row;
  logic [USW-1:0] u_scaled;
  logic [USW-1:0] u_center;
  logic [USW-1:0] u_diff;
  logic [VSW-1:0] v_scaled;
  logic [VSW-1:0] v_center;
  logic [VSW-1:0] v_diff;
  logic           u_neg;
  logic           v_neg;

  // Zero size acts as one, oversized as the maximum.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = UCW'(1);
    end else if (UCW'(cfg.image_width) > UCW'(MAX_WIDTH)) begin
      w_eff = UCW'(MAX_WIDTH);
    end else begin
      w_eff = UCW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = VCW'(1);
    end else if (VCW'(cfg.image_height) > VCW'(MAX_HEIGHT)) begin
      h_eff = VCW'(MAX_HEIGHT);
    end else begin
      h_eff = VCW'(cfg.image_height);
    end
  end

  assign last_col = (UCW'(column) + UCW'(1)) >= w_eff;
  assign last_row = (VCW'(row) + VCW'(1)) >= h_eff;

  always_comb begin
    u_scaled = USW'(column) << 4;
    u_center = USW'(cfg.center_x);
    u_neg    = u_scaled < u_center;
    u_diff   = u_neg ? (u_center - u_scaled) : (u_scaled - u_center);
    v_scaled = VSW'(row) << 4;
    v_center = VSW'(cfg.center_y);
    v_neg    = v_scaled < v_center;
    v_diff   = v_neg ? (v_center - v_scaled) : (v_scaled - v_center);
  end

  always_comb begin
    item.dx_mag    = u_diff[DMAG_W-1:0];
    item.dx_neg    = u_neg;
    item.dy_mag    = v_diff[DMAG_W-1:0];
    item.dy_neg    = v_neg;
    item.depth     = depth_mm;
    item.rgb       = {red, green, blue};
    item.frame_end = last_col && last_row;
  end

  // Advance the raster position on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column <= '0;
        row    <= last_row ? '0 : row + VW'(1);
      end else begin
        column <= column + UW'(1);
      end
    end
  end

endmodule

>>> hdl/dxyz_back.sv
// Back end: multiply pipeline, rounding, saturation and result queue.
// Depends on dxyz_pkg and dxyz_fifo.
module dxyz_back
  import dxyz_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  mid_item_t mid_item,
  input  logic      mid_empty,
  output logic      mid_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  function automatic logic [POS_W-1:0] finish(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] clamped;
    logic [MAG_W-1:0] signed_val;
    lim        = neg ? NEG_LIMIT : POS_LIMIT;
    clamped    = (mag > lim) ? lim : mag;
    signed_val = neg ? (MAG_W'(0) - clamped) : clamped;
    return signed_val[POS_W-1:0];
  endfunction

  logic [PEND_W-1:0] pending;
  logic              out_pop;
  logic              out_full;

  // Stage 1: offset times focal reciprocal.
  logic               v1;
  logic [PROD1_W-1:0] p1x, p1y;
  logic               n1x, n1y;
  logic [DEPTH_W-1:0] z1;
  logic [RGB_W-1:0]   rgb1;
  logic               fe1;
  // Stage 2: split products with depth.
  logic               v2;
  logic [PART_W-1:0]  hx, lx, hy, ly;
  logic               n2x, n2y;
  logic [DEPTH_W-1:0] z2;
  logic [RGB_W-1:0]   rgb2;
  logic               fe2;
  // Stage 3: recombined and rounded magnitude.
  logic               v3;
  logic [MAG_W-1:0]   mx, my;
  logic               n3x, n3y;
  logic [DEPTH_W-1:0] z3;
  logic [RGB_W-1:0]   rgb3;
  logic               fe3;

  logic [PROD_W-1:0]  sum_x, sum_y;
  out_item_t          push_item;

  // Issue only while the result queue has room for everything in flight.
  assign mid_pop = !mid_empty && !out_full && (pending < PEND_W'(OUT_DEPTH));
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (mid_pop && !out_pop) begin
      pending <= pending + PEND_W'(1);
    end else if (out_pop && !mid_pop) begin
      pending <= pending - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p1x  <= PROD1_W'(mid_item.dx_mag) * PROD1_W'(cfg.inv_focal_x);
    p1y  <= PROD1_W'(mid_item.dy_mag) * PROD1_W'(cfg.inv_focal_y);
    n1x  <= mid_item.dx_neg;
    n1y  <= mid_item.dy_neg;
    z1   <= mid_item.depth;
    rgb1 <= mid_item.rgb;
    fe1  <= mid_item.frame_end;

    hx   <= PART_W'(p1x[PROD1_W-1:SPLIT_W]) * PART_W'(z1);
    lx   <= PART_W'(p1x[SPLIT_W-1:0]) * PART_W'(z1);
    hy   <= PART_W'(p1y[PROD1_W-1:SPLIT_W]) * PART_W'(z1);
    ly   <= PART_W'(p1y[SPLIT_W-1:0]) * PART_W'(z1);
    n2x  <= n1x;
    n2y  <= n1y;
    z2   <= z1;
    rgb2 <= rgb1;
    fe2  <= fe1;

    mx   <= sum_x[PROD_W-1:ROUND_SH];
    my   <= sum_y[PROD_W-1:ROUND_SH];
    n3x  <= n2x;
    n3y  <= n2y;
    z3   <= z2;
    rgb3 <= rgb2;
    fe3  <= fe2;
  end

  // Round half away from zero on the magnitude.
  assign sum_x = (PROD_W'(hx) << SPLIT_W) + PROD_W'(lx) + ROUND_HALF;
  assign sum_y = (PROD_W'(hy) << SPLIT_W) + PROD_W'(ly) + ROUND_HALF;

  // A zero depth already gives zero magnitudes, so x, y and z fall out as zero.
  always_comb begin
    push_item.x_pos       = finish(mx, n3x);
    push_item.y_pos       = finish(my, n3y);
    push_item.z_mm        = z3;
    push_item.point_valid = (z3 != '0);
    push_item.rgb_packed  = rgb3;
    push_item.frame_end   = fe3;
  end

  dxyz_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (v3),
    .wdata (push_item),
    .pop   (out_pop),
    .rdata (result),
    .full  (out_full),
    .empty (empty)
  );

endmodule
